### sv/slipd_pkg.sv
// shared types and constants of the slip frame decoder
`timescale 1ns / 1ps
package slipd_pkg;

  localparam int unsigned HOLD_DEPTH = 3;
  localparam int unsigned HOLD_IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned RES_IDX_W  = $clog2(HOLD_DEPTH + 1);

  localparam logic [7:0]  SLIP_END     = 8'hC0;
  localparam logic [7:0]  SLIP_ESC     = 8'hDB;
  localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
  localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;

  localparam logic [15:0] CAP_RESET = 16'd592;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_RELEASE,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                   kind;
    logic [7:0]                  data;
    logic [HOLD_DEPTH-1:0][7:0]  held;
    logic [15:0]                 length;
    logic [15:0]                 frames;
    logic [15:0]                 overruns;
  } cmd_t;

endpackage

### sv/slipd_front.sv
// front end: unescapes line bytes, tracks frame state and issues commands
`timescale 1ns / 1ps
module slipd_front import slipd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic                       esc_q, esc_d;
  logic [15:0]                cnt_q, cnt_d;
  logic [15:0]                cap_q;
  logic [15:0]                frames_q, frames_d;
  logic [15:0]                ovr_q, ovr_d;
  logic [HOLD_DEPTH-1:0][7:0] held_q;
  logic                       held_we;
  logic [7:0]                 dec_byte;

  always_comb begin
    dec_byte = in_byte_i;
    if (esc_q && in_byte_i == SLIP_ESC_ESC) begin
      dec_byte = SLIP_ESC;
    end else if (esc_q && in_byte_i == SLIP_ESC_END) begin
      dec_byte = SLIP_END;
    end
  end

  always_comb begin
    esc_d         = esc_q;
    cnt_d         = cnt_q;
    frames_d      = frames_q;
    ovr_d         = ovr_q;
    held_we       = 1'b0;
    push_o        = 1'b0;
    cmd_o.kind    = CMD_DATA;
    cmd_o.data    = dec_byte;
    cmd_o.held    = held_q;
    cmd_o.length  = 16'd0;
    if (in_valid_i) begin
      if (in_byte_i == SLIP_ESC) begin
        esc_d = 1'b1;
      end else if (in_byte_i == SLIP_END) begin
        if (cnt_q > 16'(HOLD_DEPTH)) begin
          if (frames_q != CNT_MAX) begin
            frames_d = frames_q + 16'd1;
          end
          push_o       = 1'b1;
          cmd_o.kind   = CMD_END;
          cmd_o.length = cnt_q;
        end
        cnt_d = 16'd0;
        esc_d = 1'b0;
      end else begin
        esc_d = 1'b0;
        if (cnt_q >= cap_q) begin
          if (ovr_q != CNT_MAX) begin
            ovr_d = ovr_q + 16'd1;
          end
        end else begin
          cnt_d = cnt_q + 16'd1;
          if (cnt_q < 16'(HOLD_DEPTH)) begin
            held_we = 1'b1;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = (cnt_q == 16'(HOLD_DEPTH)) ? CMD_RELEASE : CMD_DATA;
          end
        end
      end
    end
    cmd_o.frames   = frames_d;
    cmd_o.overruns = ovr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= 1'b0;
      cnt_q    <= 16'd0;
      cap_q    <= CAP_RESET;
      frames_q <= 16'd0;
      ovr_q    <= 16'd0;
    end else begin
      esc_q    <= esc_d;
      cnt_q    <= cnt_d;
      frames_q <= frames_d;
      ovr_q    <= ovr_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[cnt_q[HOLD_IDX_W-1:0]] <= dec_byte;
    end
  end

endmodule

### sv/slipd_queue.sv
// two-entry command queue between front and back end
`timescale 1ns / 1ps
module slipd_queue import slipd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = count_q == 2'd2;
  assign empty_o   = count_q == 2'd0;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### sv/slipd_back.sv
// back end: expands one command into its result items
`timescale 1ns / 1ps
module slipd_back import slipd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  out_data_o,
  output logic [15:0] out_length_o,
  output logic [15:0] out_frames_o,
  output logic [15:0] out_overruns_o,
  output logic        out_last_o
);

  logic                 busy_q;
  cmd_t                 cmd_q;
  logic [RES_IDX_W-1:0] idx_q;
  logic                 out_acc;

  assign out_valid_o = busy_q;
  assign out_acc     = busy_q && out_ready_i;
  assign out_last_o  = (cmd_q.kind != CMD_RELEASE) || (idx_q == RES_IDX_W'(HOLD_DEPTH));
  assign q_pop_o     = !q_empty_i && (!busy_q || (out_acc && out_last_o));

  always_comb begin
    out_kind_o     = (cmd_q.kind == CMD_END) ? KIND_END : KIND_DATA;
    out_length_o   = (cmd_q.kind == CMD_END) ? cmd_q.length : 16'd0;
    out_frames_o   = cmd_q.frames;
    out_overruns_o = cmd_q.overruns;
    out_data_o     = cmd_q.data;
    if (cmd_q.kind == CMD_END) begin
      out_data_o = 8'd0;
    end else if (cmd_q.kind == CMD_RELEASE && idx_q < RES_IDX_W'(HOLD_DEPTH)) begin
      out_data_o = cmd_q.held[idx_q[HOLD_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_acc) begin
      if (out_last_o) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= RES_IDX_W'(HOLD_DEPTH))
    else $error("result index beyond release length");

  a_single_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cmd_q.kind != CMD_RELEASE |-> idx_q == '0)
    else $error("single-result command with nonzero index");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_o |=> busy_q && idx_q == $past(idx_q) + RES_IDX_W'(1))
    else $error("release sequence did not advance");

endmodule

### sv/slip_frame_decoder_unit.sv
// top level of the slip frame decoder
`timescale 1ns / 1ps
// Removes SLIP framing from a received byte stream, one line byte per item.
// A byte is taken every cycle while the two-entry command queue has room;
// most bytes give at most one result, which passes the queue stage and
// then the result stage before it is offered on the output.
// The fourth stored byte of a frame releases the three held-back bytes with
// it, so that item gives four results from the result stage, during which
// up to two further commands may queue. End of a frame of at least four
// bytes gives one end-marker result carrying the length.
// The frame capacity register is written over the cfg channel, reset 592.
module slip_frame_decoder_unit import slipd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // data_byte, frame_length, frames_seen, overrun_total
  output logic        m_axis_tuser,   // out_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  cmd_t        pop_cmd;
  logic        q_full;
  logic        q_empty;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;
  logic [15:0] frames_seen;
  logic [15:0] overrun_total;

  assign s_axis_tready = !q_full;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tdata  = {overrun_total, frames_seen, frame_length, data_byte};

  slipd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  slipd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  slipd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (pop_cmd),
    .q_pop_o        (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_kind_o     (m_axis_tuser),
    .out_data_o     (data_byte),
    .out_length_o   (frame_length),
    .out_frames_o   (frames_seen),
    .out_overruns_o (overrun_total),
    .out_last_o     (m_axis_tlast)
  );

endmodule
